FILE: sv/swmk_pkg.sv
// swmk_pkg: shared constants, types and the arctangent table for the
// swerve module kinematics block. No dependencies.
package swmk_pkg;

  localparam int NumModules   = 4;
  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;

  localparam int VelW  = 16;  // command fields
  localparam int ArmW  = 16;  // arm registers
  localparam int ProdW = 32;  // rot_rate * arm
  localparam int DW    = 33;  // dx, dy in Q.26
  localparam int XW    = 36;  // CORDIC x, y with gain headroom
  localparam int ZW    = 27;  // CORDIC angle, Q.24
  localparam int StW   = 5;   // stage number
  localparam int MagW  = 27;  // magnitudes above this always clip
  localparam int AzW   = 25;  // |angle| bits
  localparam int ScW   = 23;  // Q.16 scale constants
  localparam int CfgIdxW = 4;

  localparam logic [1:0] LastIdx = 2'(NumModules - 1);

  localparam logic signed [ZW-1:0] HalfPiQ24 = 27'sd26353589;
  localparam logic [ScW-1:0] PowerScale = 23'd4806160;
  localparam logic [ScW-1:0] ServoScale = 23'd5319493;
  localparam logic [7:0] PowerLimit = 8'd100;
  localparam logic [7:0] ServoLimit = 8'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CfgM0ArmX = 4'd0, CfgM0ArmY = 4'd1, CfgM1ArmX = 4'd2, CfgM1ArmY = 4'd3,
    CfgM2ArmX = 4'd4, CfgM2ArmY = 4'd5, CfgM3ArmX = 4'd6, CfgM3ArmY = 4'd7
  } swmk_cfg_e;

  // side info that rides along with each module beat
  typedef struct packed {
    logic       vld;
    logic [1:0] idx;
    logic       last;
    logic       dy_neg;
    logic       dy_zero;
    logic       dx_pos;
    logic       dx_neg;
  } swmk_tag_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [StW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 27'sd13176795;
      5'd1:  r = 27'sd7778716;
      5'd2:  r = 27'sd4110060;
      5'd3:  r = 27'sd2086331;
      5'd4:  r = 27'sd1047214;
      5'd5:  r = 27'sd524117;
      5'd6:  r = 27'sd262123;
      5'd7:  r = 27'sd131069;
      5'd8:  r = 27'sd65536;
      5'd9:  r = 27'sd32768;
      5'd10: r = 27'sd16384;
      5'd11: r = 27'sd8192;
      5'd12: r = 27'sd4096;
      5'd13: r = 27'sd2048;
      5'd14: r = 27'sd1024;
      5'd15: r = 27'sd512;
      5'd16: r = 27'sd256;
      5'd17: r = 27'sd128;
      5'd18: r = 27'sd64;
      5'd19: r = 27'sd32;
      5'd20: r = 27'sd16;
      5'd21: r = 27'sd8;
      5'd22: r = 27'sd4;
      5'd23: r = 27'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/swmk_cordic_stage.sv
// swmk_cordic_stage: one registered vectoring-mode CORDIC iteration.
// Depends on swmk_pkg.
module swmk_cordic_stage import swmk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [StW-1:0]       stage_i,
  input  swmk_tag_t            tag_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output swmk_tag_t            tag_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  swmk_tag_t tag_q;

  // arithmetic shift floors, as required
  assign xs = x_i >>> stage_i;
  assign ys = y_i >>> stage_i;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_q24(stage_i);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_q24(stage_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign tag_o = tag_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

FILE: sv/swmk_scale.sv
// swmk_scale: two-stage scaling of CORDIC magnitude and angle to motor
// power and servo position, with saturation. Depends on swmk_pkg.
module swmk_scale import swmk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swmk_tag_t            tag_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 valid_o,
  output logic [1:0]           module_index_o,
  output logic signed [7:0]    motor_power_o,
  output logic signed [7:0]    servo_position_o,
  output logic                 power_clipped_o,
  output logic                 last_of_run_o
);

  localparam int PpW = MagW + ScW;
  localparam int PsW = AzW + ScW;

  logic                 x_pos, hi_d, hi_q;
  logic [MagW-1:0]      mag;
  logic signed [ZW-1:0] z_eff, az;
  logic [PpW-1:0]       pp_d, pp_q;
  logic [PsW-1:0]       ps_d, ps_q;
  logic                 zneg_q;
  swmk_tag_t            tag_q;

  // stage A: zero-dy angle override and both products
  always_comb begin
    if (tag_i.dy_zero) begin
      if (tag_i.dx_pos)      z_eff = HalfPiQ24;
      else if (tag_i.dx_neg) z_eff = -HalfPiQ24;
      else                   z_eff = '0;
    end else begin
      z_eff = z_i;
    end
    az    = z_eff[ZW-1] ? -z_eff : z_eff;
    x_pos = !x_i[XW-1] && (x_i != '0);
    mag   = x_pos ? x_i[MagW-1:0] : '0;
    hi_d  = x_pos && (x_i[XW-2:MagW] != '0);
    pp_d  = PpW'(mag) * PpW'(PowerScale);
    ps_d  = PsW'(az[AzW-1:0]) * PsW'(ServoScale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    ps_q   <= ps_d;
    hi_q   <= hi_d;
    zneg_q <= z_eff[ZW-1];
  end

  // stage B: shift, saturate, sign
  logic [7:0] p_full, s_full, p_sat, s_sat;
  logic       clip;
  logic signed [7:0] power_d, servo_d;
  logic signed [7:0] power_q, servo_q;
  logic clip_q;
  swmk_tag_t out_q;

  always_comb begin
    p_full  = pp_q[49:42];
    s_full  = ps_q[47:40];
    clip    = hi_q || (p_full > PowerLimit);
    p_sat   = clip ? PowerLimit : p_full;
    s_sat   = (s_full > ServoLimit) ? ServoLimit : s_full;
    power_d = tag_q.dy_neg ? -$signed(p_sat) : $signed(p_sat);
    servo_d = zneg_q ? -$signed(s_sat) : $signed(s_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    power_q <= power_d;
    servo_q <= servo_d;
    clip_q  <= clip;
  end

  assign valid_o          = out_q.vld;
  assign module_index_o   = out_q.idx;
  assign last_of_run_o    = out_q.last;
  assign motor_power_o    = power_q;
  assign servo_position_o = servo_q;
  assign power_clipped_o  = clip_q;

endmodule

FILE: sv/swerve_module_kinematics_top.sv
// swerve_module_kinematics_top: four-module swerve inverse kinematics.
// Depends on swmk_pkg, swmk_cordic_stage and swmk_scale.
//
// Usage:
//   Command channel: drive vel_x_i, vel_y_i, rot_rate_i with start high;
//   the beat is taken at a clock edge where busy is low. The command is
//   held internally, so the fields may change after that edge.
//   Result channel: valid_o marks one result beat per cycle, in module order
//   0..3; last_of_run_o flags module 3. The receiver cannot stall, so the
//   pipeline never stops.
//   Throughput: the sequencer issues one module per cycle, and busy is high
//   until it issues module 3, so a new command can be taken at the edge
//   that ends the issue of module 3.
//   Pipeline: each module's result passes 3 front-end stages, 16 CORDIC
//   stages and 2 scale stages.
//   Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write the eight arm
//   registers (index 0..7); other indexes are ignored. Write only while idle.
//   Reset: the arm registers return to their default geometry and all
//   valid bits clear; no beats are in flight.
module swerve_module_kinematics_top import swmk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [VelW-1:0] vel_x_i,
  input  logic signed [VelW-1:0] vel_y_i,
  input  logic signed [VelW-1:0] rot_rate_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ArmW-1:0]       cfg_data_i,
  output logic                  valid_o,
  output logic [1:0]            module_index_o,
  output logic signed [7:0]     motor_power_o,
  output logic signed [7:0]     servo_position_o,
  output logic                  power_clipped_o,
  output logic                  last_of_run_o
);

  // ---------------- arm registers ----------------
  logic signed [ArmW-1:0] arm_x_q [4];
  logic signed [ArmW-1:0] arm_y_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_x_q[0] <= 16'sd2648;  arm_y_q[0] <= 16'sd2648;
      arm_x_q[1] <= -16'sd2648; arm_y_q[1] <= 16'sd2648;
      arm_x_q[2] <= -16'sd2648; arm_y_q[2] <= -16'sd2648;
      arm_x_q[3] <= 16'sd2648;  arm_y_q[3] <= -16'sd2648;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgM0ArmX: arm_x_q[0] <= cfg_data_i;
        CfgM0ArmY: arm_y_q[0] <= cfg_data_i;
        CfgM1ArmX: arm_x_q[1] <= cfg_data_i;
        CfgM1ArmY: arm_y_q[1] <= cfg_data_i;
        CfgM2ArmX: arm_x_q[2] <= cfg_data_i;
        CfgM2ArmY: arm_y_q[2] <= cfg_data_i;
        CfgM3ArmX: arm_x_q[3] <= cfg_data_i;
        CfgM3ArmY: arm_y_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- module sequencer ----------------
  logic       act_q;
  logic [1:0] cnt_q;
  logic signed [VelW-1:0] vx_q, vy_q, w_q;
  logic       take;

  assign busy = act_q && (cnt_q != LastIdx);
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else if (take) begin
      act_q <= 1'b1;
      cnt_q <= '0;
    end else if (act_q) begin
      if (cnt_q == LastIdx) act_q <= 1'b0;
      else                  cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
      w_q  <= rot_rate_i;
    end
  end

  swmk_tag_t issue_tag;
  always_comb begin
    issue_tag      = '0;
    issue_tag.vld  = act_q;
    issue_tag.idx  = cnt_q;
    issue_tag.last = (cnt_q == LastIdx);
  end

  // ---------------- stage 1: lever products ----------------
  swmk_tag_t s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [ProdW-1:0] px_q, py_q;
  logic signed [VelW-1:0]  vx1_q, vy1_q;

  always_ff @(posedge clk_i) begin
    px_q  <= w_q * arm_x_q[cnt_q];
    py_q  <= w_q * arm_y_q[cnt_q];
    vx1_q <= vx_q;
    vy1_q <= vy_q;
  end

  // ---------------- stage 2: dx, dy in Q.26 ----------------
  logic signed [DW-1:0] dx_q, dy_q;
  always_ff @(posedge clk_i) begin
    dx_q <= (DW'(vx1_q) <<< 14) + DW'(px_q);
    dy_q <= (DW'(vy1_q) <<< 14) - DW'(py_q);
  end

  // ---------------- stage 3: fold into right half-plane ----------------
  logic signed [XW-1:0] x3_q, y3_q;
  swmk_tag_t s3_tag_d;
  always_comb begin
    s3_tag_d         = s2_tag_q;
    s3_tag_d.dy_neg  = dy_q[DW-1];
    s3_tag_d.dy_zero = (dy_q == '0);
    s3_tag_d.dx_pos  = !dx_q[DW-1] && (dx_q != '0);
    s3_tag_d.dx_neg  = dx_q[DW-1];
  end

  always_ff @(posedge clk_i) begin
    x3_q <= dy_q[DW-1] ? -XW'(dy_q) : XW'(dy_q);
    y3_q <= dy_q[DW-1] ? -XW'(dx_q) : XW'(dx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else begin
      s1_tag_q <= issue_tag;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s3_tag_d;
    end
  end

  // ---------------- CORDIC pipeline ----------------
  swmk_tag_t            c_tag [CordicStages+1];
  logic signed [XW-1:0] c_x   [CordicStages+1];
  logic signed [XW-1:0] c_y   [CordicStages+1];
  logic signed [ZW-1:0] c_z   [CordicStages+1];

  assign c_tag[0] = s3_tag_q;
  assign c_x[0]   = x3_q;
  assign c_y[0]   = y3_q;
  assign c_z[0]   = '0;

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    swmk_cordic_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .stage_i(StW'(g)),
      .tag_i  (c_tag[g]),
      .x_i    (c_x[g]),
      .y_i    (c_y[g]),
      .z_i    (c_z[g]),
      .tag_o  (c_tag[g+1]),
      .x_o    (c_x[g+1]),
      .y_o    (c_y[g+1]),
      .z_o    (c_z[g+1])
    );
  end

  // ---------------- scaling and output ----------------
  swmk_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tag_i           (c_tag[CordicStages]),
    .x_i             (c_x[CordicStages]),
    .z_i             (c_z[CordicStages]),
    .valid_o         (valid_o),
    .module_index_o  (module_index_o),
    .motor_power_o   (motor_power_o),
    .servo_position_o(servo_position_o),
    .power_clipped_o (power_clipped_o),
    .last_of_run_o   (last_of_run_o)
  );

  // ---------------- assertions ----------------
  a_take_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (act_q && cnt_q == '0))
    else $error("accepted command did not restart the sequencer");

  a_busy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> act_q)
    else $error("busy without an active command");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_of_run_o == (module_index_o == LastIdx)))
    else $error("last_of_run disagrees with module index");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && power_clipped_o) |->
      (motor_power_o == 8'sd100 || motor_power_o == -8'sd100))
    else $error("clipped power not at limit");

endmodule

FILE: tb/sv/tb_swerve_module_kinematics_top.sv
// Self-checking testbench for swerve_module_kinematics_top: directed and
// random velocity commands checked against a built-in CORDIC predictor.
// Depends on swmk_pkg and the block's RTL.
module tb_swerve_module_kinematics_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swmk_pkg::*;

  // one expected result beat
  typedef struct {
    logic [1:0]       idx;
    logic signed [7:0] power;
    logic signed [7:0] servo;
    logic             clipped;
    logic             last;
  } drive_t;

  // arctangent table in Q.24, one entry per CORDIC stage
  localparam longint AtanTbl [16] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
  localparam longint DrainCycles = 30;  // longer than the pipeline latency

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [VelW-1:0] vel_x_i = '0, vel_y_i = '0, rot_rate_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ArmW-1:0] cfg_data_i = '0;
  logic valid_o;
  logic [1:0] module_index_o;
  logic signed [7:0] motor_power_o, servo_position_o;
  logic power_clipped_o, last_of_run_o;

  longint arm_geom [8];   // predictor copy of the arm registers
  drive_t drive_q [$];    // expected beats, oldest first
  int mismatches = 0;

  swerve_module_kinematics_top i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Work out the four module beats that one command produces.
  task automatic predict_drives(input logic signed [15:0] vx, vy, w);
    longint dx, dy, x, y, z, xs, ys;
    longint unsigned mag, p, az, s;
    drive_t d;
    for (int m = 0; m < NumModules; m++) begin
      dx = longint'(vx) * 16384 + longint'(w) * arm_geom[2*m];
      dy = longint'(vy) * 16384 - longint'(w) * arm_geom[2*m+1];
      // pre-rotate into the right half plane
      x = (dy < 0) ? -dy : dy;
      y = (dy < 0) ? -dx : dx;
      z = 0;
      for (int i = 0; i < CordicStages; i++) begin
        xs = x >>> i;   // arithmetic shift floors
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += AtanTbl[i];
        end else begin
          x -= ys; y += xs; z -= AtanTbl[i];
        end
      end
      // straight sideways: exact quarter turn
      if (dy == 0)
        z = (dx > 0) ? longint'(HalfPiQ24) : ((dx < 0) ? -longint'(HalfPiQ24) : 0);
      mag = (x > 0) ? longint'(x) : 0;
      p = (mag * 4806160) >> 42;
      d.clipped = (p > 100);
      if (p > 100) p = 100;
      d.power = (dy < 0) ? -8'(p) : 8'(p);
      az = (z < 0) ? -z : z;
      s = (az * 5319493) >> 40;
      if (s > 127) s = 127;
      d.servo = (z < 0) ? -8'(s) : 8'(s);
      d.idx = 2'(m);
      d.last = (m == NumModules - 1);
      drive_q.push_back(d);
    end
  endtask

  // Send one command after a random gap; start stays high for back-to-back beats.
  task automatic send_cmd(input logic signed [15:0] vx, vy, w);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;  // stretches without gaps
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    vel_x_i <= vx;
    vel_y_i <= vy;
    rot_rate_i <= w;
    do @(posedge clk_i); while (busy);
    predict_drives(vx, vy, w);
  endtask

  // Let the pipeline empty before touching the arm registers.
  task automatic drain();
    @(posedge clk_i);
    start <= 1'b0;
    wait (drive_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write beat; the enable drops on the following edge
  task automatic write_arm(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < 8) arm_geom[idx[2:0]] = longint'(signed'(data));
  endtask

  // Random command: full-range fields mixed with small ones so that
  // unclipped powers and all angle quadrants show up.
  task automatic send_random();
    logic signed [15:0] vx, vy, w;
    vx = 16'($urandom); vy = 16'($urandom); w = 16'($urandom);
    case ($urandom_range(0, 4))
      0: begin vx = vx >>> 4; vy = vy >>> 4; w = w >>> 4; end
      1: begin vx = vx >>> 3; vy = vy >>> 3; w = '0; end
      2: vy = '0;
      3: begin vx = vx >>> 2; vy = vy >>> 2; w = w >>> 6; end
      default: ;
    endcase
    send_cmd(vx, vy, w);
  endtask

  // Default geometry: extremes, every quadrant, zero dy, saturation.
  task automatic test_default_geometry();
    send_cmd(16'sd0, 16'sd0, 16'sd0);          // all zero: angle 0
    send_cmd(16'sd100, 16'sd0, 16'sd0);        // dy zero, dx positive
    send_cmd(-16'sd100, 16'sd0, 16'sd0);       // dy zero, dx negative
    send_cmd(16'sd0, 16'sd200, 16'sd0);
    send_cmd(16'sd0, -16'sd200, 16'sd0);       // negative dy
    send_cmd(16'sd300, -16'sd300, 16'sd0);
    send_cmd(-16'sd300, 16'sd300, 16'sd0);
    send_cmd(16'sd0, 16'sd0, 16'sd500);        // pure rotation
    send_cmd(16'sd0, 16'sd0, -16'sd500);
    send_cmd(16'sd32767, 16'sd32767, 16'sd32767);
    send_cmd(-16'sd32768, -16'sd32768, -16'sd32768);
    send_cmd(16'sd32767, -16'sd32768, 16'sd0);
    send_cmd(-16'sd32768, 16'sd0, 16'sd32767);
    send_cmd(16'sd5000, 16'sd5000, 16'sd0);    // clipped
    send_cmd(16'sd1, -16'sd1, 16'sd1);
    send_cmd(-16'sd1, -16'sd1, -16'sd1);
  endtask

  // Arm registers at their extremes, plus ignored indexes.
  task automatic test_arm_extremes();
    drain();
    for (int r = 0; r < 8; r++) write_arm(CfgIdxW'(r), (r % 2) ? 16'h8000 : 16'h7fff);
    write_arm(4'd8, 16'h1234);
    write_arm(4'd15, 16'hffff);
    send_cmd(16'sd0, 16'sd0, 16'sd10);
    send_cmd(16'sd0, 16'sd0, -16'sd32768);
    send_cmd(16'sd32767, 16'sd0, 16'sd32767);
    send_cmd(16'sd7, 16'sd3, -16'sd2);
    for (int n = 0; n < 50; n++) send_random();
  endtask

  // Several random geometries, zero arms and reset geometry among them.
  task automatic test_random_geometry();
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int r = 0; r < 8; r++) begin
        case (ph)
          0: write_arm(CfgIdxW'(r), '0);
          1: write_arm(CfgIdxW'(r), (r % 2) ? 16'h7fff : 16'h8000);
          4: write_arm(CfgIdxW'(r), ((r == 0) || (r == 1) || (r == 3) || (r == 6))
                                    ? 16'sd2648 : -16'sd2648);
          default: write_arm(CfgIdxW'(r), 16'($urandom));
        endcase
      end
      for (int n = 0; n < 50; n++) send_random();
    end
  endtask

  // Checker: every result beat against the oldest expectation.
  always @(posedge clk_i) begin
    drive_t e;
    if (valid_o) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: module %0d", module_index_o);
      end else begin
        e = drive_q.pop_front();
        if (module_index_o !== e.idx || motor_power_o !== e.power ||
            servo_position_o !== e.servo || power_clipped_o !== e.clipped ||
            last_of_run_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp idx %0d pwr %0d servo %0d clip %0d last %0d, ",
                      "got %0d %0d %0d %0d %0d"},
                     e.idx, e.power, e.servo, e.clipped, e.last, module_index_o,
                     motor_power_o, servo_position_o, power_clipped_o, last_of_run_o);
        end
      end
    end
  end

  initial begin
    arm_geom = '{2648, 2648, -2648, 2648, -2648, -2648, 2648, -2648};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_geometry();
    test_arm_extremes();
    test_random_geometry();
    drain();
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
sv/swmk_pkg.sv
sv/swmk_cordic_stage.sv
sv/swmk_scale.sv
sv/swerve_module_kinematics_top.sv
tb/sv/tb_swerve_module_kinematics_top.sv
